// ===== rtl/sik_pkg.sv =====
// Shared constants, tables and types of the SCARA inverse kinematics block.
package sik_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int CORDIC_STAGES_MAX = 32;

  // angles are Q30 radians; 37 bits hold +-64 rad, about +-20 pi
  localparam int ANG_W = 37;
  // CORDIC operands: |x|, |y| <= 2^30, scaled by 2^24 inside
  localparam int CRD_IN_W = 32;
  localparam int CRD_SHIFT = 24;
  localparam int CRD_W = 58;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 37'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 37'sd1686629713;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STAGES_MAX] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L1    = 3'd0,
    CFG_L2    = 3'd1,
    CFG_BASE  = 3'd2,
    CFG_LIFT  = 3'd3,
    CFG_SHLD  = 3'd4,
    CFG_ELBOW = 3'd5
  } cfg_idx_e;

endpackage

// ===== rtl/sik_target_if.sv =====
// Stream interface carrying one target word.
interface sik_target_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic signed [23:0] target_z;
  logic               elbow_convex;

  modport source (output valid, output target_x, output target_y, output target_z,
                  output elbow_convex, input ready);
  modport sink (input valid, input target_x, input target_y, input target_z,
                input elbow_convex, output ready);
endinterface

// ===== rtl/sik_joint_if.sv =====
// Stream interface carrying one joint result word.
interface sik_joint_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] lift_offset;
  logic signed [19:0] shoulder_angle;
  logic signed [19:0] elbow_angle;
  logic               in_range;

  modport source (output valid, output lift_offset, output shoulder_angle,
                  output elbow_angle, output in_range, input ready);
  modport sink (input valid, input lift_offset, input shoulder_angle,
                input elbow_angle, input in_range, output ready);
endinterface

// ===== rtl/sik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module sik_isqrt #(
  parameter int IW = 64,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [IW/2-1:0] root_o,
  output logic            rem_nz_o,
  output logic [SW-1:0]   side_o
);
  localparam int N = IW / 2;
  localparam int RW = N + 3;

  logic          vld_q  [1:N];
  logic [IW-1:0] rad_q  [1:N];
  logic [N-1:0]  root_q [1:N];
  logic [RW-1:0] rem_q  [1:N];
  logic [SW-1:0] side_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          v_in;
    logic [IW-1:0] r_in;
    logic [N-1:0]  rt_in;
    logic [RW-1:0] rm_in;
    logic [SW-1:0] s_in;
    logic [RW-1:0] rm_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_in  = vld_i;
      assign r_in  = rad_i;
      assign rt_in = '0;
      assign rm_in = '0;
      assign s_in  = side_i;
    end else begin : g_body
      assign v_in  = vld_q[k];
      assign r_in  = rad_q[k];
      assign rt_in = root_q[k];
      assign rm_in = rem_q[k];
      assign s_in  = side_q[k];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rm_sh = {rm_in[RW-3:0], r_in[IW-1-2*k -: 2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign ge    = rm_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= r_in;
        root_q[k+1] <= {rt_in[N-2:0], ge};
        rem_q[k+1]  <= ge ? rm_sh - trial : rm_sh;
        side_q[k+1] <= s_in;
      end
    end
  end

  assign vld_o    = vld_q[N];
  assign root_o   = root_q[N];
  assign rem_nz_o = |rem_q[N];
  assign side_o   = side_q[N];

endmodule

// ===== rtl/sik_cordic.sv =====
// Pipelined vectoring CORDIC giving the Q30 angle of a vector, with side data.
module sik_cordic #(
  parameter int STAGES = sik_pkg::CORDIC_STAGES_DEF,
  parameter int SW = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [sik_pkg::CRD_IN_W-1:0] y_i,
  input  logic signed [sik_pkg::CRD_IN_W-1:0] x_i,
  input  logic [SW-1:0]                       side_i,
  output logic                                vld_o,
  output logic signed [sik_pkg::ANG_W-1:0]    ang_o,
  output logic [SW-1:0]                       side_o
);
  import sik_pkg::*;

  localparam int PAD = CRD_W - CRD_IN_W - CRD_SHIFT;

  logic                     vld_q  [0:STAGES];
  logic signed [CRD_W-1:0]  x_q    [0:STAGES];
  logic signed [CRD_W-1:0]  y_q    [0:STAGES];
  logic signed [ANG_W-1:0]  z_q    [0:STAGES];
  logic [SW-1:0]            side_q [0:STAGES];

  logic                      neg;
  logic signed [CRD_IN_W-1:0] xa;
  logic signed [CRD_IN_W-1:0] ya;
  logic signed [ANG_W-1:0]    base;

  // left half plane: rotate by pi first
  always_comb begin
    neg  = x_i[CRD_IN_W-1];
    xa   = neg ? -x_i : x_i;
    ya   = neg ? -y_i : y_i;
    base = '0;
    if (neg) begin
      base = y_i[CRD_IN_W-1] ? -PI_Q30 : PI_Q30;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= {{PAD{xa[CRD_IN_W-1]}}, xa, {CRD_SHIFT{1'b0}}};
      y_q[0]    <= {{PAD{ya[CRD_IN_W-1]}}, ya, {CRD_SHIFT{1'b0}}};
      z_q[0]    <= base;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
    logic signed [ANG_W-1:0] at;
    logic                    up;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign at = $signed({{(ANG_W-30){1'b0}}, ATAN_Q30[i]});
    assign up = !y_q[i][CRD_W-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= up ? x_q[i] + dy : x_q[i] - dy;
        y_q[i+1]    <= up ? y_q[i] - dx : y_q[i] + dx;
        z_q[i+1]    <= up ? z_q[i] + at : z_q[i] - at;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign vld_o  = vld_q[STAGES];
  assign ang_o  = z_q[STAGES];
  assign side_o = side_q[STAGES];

endmodule

// ===== rtl/scara_inverse_kinematics.sv =====
// Top level: SCARA inverse kinematics, fully pipelined.
//
//  channel  | dir | word
//  ---------+-----+------------------------------------------------------
//  tgt_i    | in  | target_x, target_y, target_z, elbow_convex
//  res_o    | out | lift_offset, shoulder_angle, elbow_angle, in_range
//  cfg_*_i  | in  | write enable, register index, 24 bit data
//
// One word per cycle enters while res_o is not stalled; the pipeline depth is set by the
// two 32/31 stage square roots, the 31 stage divider and the CORDIC pipeline.
// Reset clears the valid bits and the configuration registers.
// A stall on res_o freezes every stage at once; nothing is lost or repeated.
module scara_inverse_kinematics #(
  parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sik_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sik_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sik_target_if.sink                       tgt_i,
  sik_joint_if.source                      res_o
);
  import sik_pkg::*;

  localparam int DW = 58;   // divider operand width
  localparam int QW = 31;   // quotient bits, Q30 up to 1.0
  localparam int DSTEPS = 31;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [24:0] lift;
    logic               cv;
    logic               ok;
    logic [DW-1:0]      acn;
    logic [49:0]        asn;
    logic [46:0]        asd;
  } geo_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [24:0] lift;
    logic               cv;
    logic               ok;
    logic               na;
    logic               nb;
  } dsd_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [24:0] lift;
    logic               cv;
    logic               ok;
    logic signed [31:0] ca;
  } trg_t;

  // ---------------- configuration
  logic [22:0]        l1_q, l2_q;
  logic signed [23:0] base_q;
  logic [23:0]        lift_lim_q;
  logic [18:0]        shld_lim_q, elb_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q       <= '0;
      l2_q       <= '0;
      base_q     <= '0;
      lift_lim_q <= '0;
      shld_lim_q <= '0;
      elb_lim_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_L1:    l1_q       <= cfg_data_i[22:0];
        CFG_L2:    l2_q       <= cfg_data_i[22:0];
        CFG_BASE:  base_q     <= cfg_data_i;
        CFG_LIFT:  lift_lim_q <= cfg_data_i;
        CFG_SHLD:  shld_lim_q <= cfg_data_i[18:0];
        CFG_ELBOW: elb_lim_q  <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || res_o.ready;
  assign tgt_i.ready = en;

  // ---------------- s1: squares
  logic signed [47:0] xx_p, yy_p;
  logic [23:0]        lsum;
  logic               vld1_q;
  logic signed [23:0] x1_q, y1_q;
  logic signed [24:0] lift1_q;
  logic               cv1_q;
  logic [46:0]        xx1_q, yy1_q;
  logic [45:0]        l11_q, l22_q, l12_q;
  logic [47:0]        rr1_q;

  assign xx_p = tgt_i.target_x * tgt_i.target_x;
  assign yy_p = tgt_i.target_y * tgt_i.target_y;
  assign lsum = {1'b0, l1_q} + {1'b0, l2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= tgt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= tgt_i.target_x;
      y1_q    <= tgt_i.target_y;
      cv1_q   <= tgt_i.elbow_convex;
      lift1_q <= $signed({tgt_i.target_z[23], tgt_i.target_z}) - $signed({base_q[23], base_q});
      xx1_q   <= xx_p[46:0];
      yy1_q   <= yy_p[46:0];
      l11_q   <= l1_q * l1_q;
      l22_q   <= l2_q * l2_q;
      l12_q   <= l1_q * l2_q;
      rr1_q   <= lsum * lsum;
    end
  end

  // ---------------- s2: reach and law of cosines numerators
  logic [47:0]   r2;
  logic [DW-1:0] acn_t;
  logic          vld2_q;
  logic [47:0]   r2_q;
  geo_t          g2_q;

  assign r2    = {1'b0, xx1_q} + {1'b0, yy1_q};
  assign acn_t = {12'b0, l11_q} + {10'b0, r2} - {12'b0, l22_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q      <= r2;
      g2_q.x    <= x1_q;
      g2_q.y    <= y1_q;
      g2_q.lift <= lift1_q;
      g2_q.cv   <= cv1_q;
      g2_q.ok   <= (r2 != '0) && (r2 <= rr1_q);
      g2_q.acn  <= {acn_t[DW-9:0], 8'b0};
      g2_q.asn  <= {2'b0, r2} - {4'b0, l11_q} - {4'b0, l22_q};
      g2_q.asd  <= {l12_q, 1'b0};
    end
  end

  // ---------------- reach root: R = ceil(sqrt(r2 * 65536))
  logic        vld_a;
  logic [31:0] root_a;
  logic        nz_a;
  geo_t        g_a;

  sik_isqrt #(.IW(64), .SW($bits(geo_t))) u_reach_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (vld2_q),
    .rad_i    ({r2_q, 16'b0}),
    .side_i   (g2_q),
    .vld_o    (vld_a),
    .root_o   (root_a),
    .rem_nz_o (nz_a),
    .side_o   (g_a)
  );

  // ---------------- s3 round up, s4 denominator, s5 range checks
  logic        vld3_q, vld4_q, vld5_q;
  logic [32:0] rq3_q;
  geo_t        g3_q, g4_q;
  logic [56:0] acd4_q;
  logic [55:0] l1rq;
  logic [DW-1:0] mag_acn;
  logic [49:0]   mag_asn;
  dsd_t          c5_q;
  logic [DW-1:0] m5_q [2];
  logic [DW-1:0] d5_q [2];

  assign l1rq    = l1_q * rq3_q;
  assign mag_acn = g4_q.acn[DW-1] ? -g4_q.acn : g4_q.acn;
  assign mag_asn = g4_q.asn[49] ? -g4_q.asn : g4_q.asn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else if (en) begin
      vld3_q <= vld_a;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq3_q   <= {1'b0, root_a} + {32'b0, nz_a};
      g3_q    <= g_a;
      acd4_q  <= {l1rq, 1'b0};
      g4_q    <= g3_q;
      c5_q.x    <= g4_q.x;
      c5_q.y    <= g4_q.y;
      c5_q.lift <= g4_q.lift;
      c5_q.cv   <= g4_q.cv;
      c5_q.na   <= g4_q.acn[DW-1];
      c5_q.nb   <= g4_q.asn[49];
      c5_q.ok   <= g4_q.ok && (acd4_q != '0) && (g4_q.asd != '0) &&
                   (mag_acn <= {1'b0, acd4_q}) && (mag_asn <= {3'b0, g4_q.asd});
      m5_q[0] <= mag_acn;
      d5_q[0] <= {1'b0, acd4_q};
      m5_q[1] <= {8'b0, mag_asn};
      d5_q[1] <= {11'b0, g4_q.asd};
    end
  end

  // ---------------- divider: two lanes, one quotient bit per stage
  logic          dv_vld_q [1:DSTEPS];
  dsd_t          dv_c_q   [1:DSTEPS];
  logic [DW-1:0] dv_rem_q [1:DSTEPS][2];
  logic [DW-1:0] dv_den_q [1:DSTEPS][2];
  logic [QW-1:0] dv_q_q   [1:DSTEPS][2];

  for (genvar k = 0; k < DSTEPS; k++) begin : g_div
    logic v_in;
    dsd_t c_in;

    if (k == 0) begin : g_src
      assign v_in = vld5_q;
      assign c_in = c5_q;
    end else begin : g_src
      assign v_in = dv_vld_q[k];
      assign c_in = dv_c_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_c_q[k+1] <= c_in;
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [DW-1:0] den;
      logic [DW:0]   sh;
      logic          ge;
      logic [DW:0]   nr;
      logic [QW-1:0] q_in;

      if (k == 0) begin : g_init
        // integer part of the ratio is 0 or 1
        assign den  = d5_q[j];
        assign sh   = {1'b0, m5_q[j]};
        assign q_in = '0;
      end else begin : g_next
        assign den  = dv_den_q[k][j];
        assign sh   = {dv_rem_q[k][j], 1'b0};
        assign q_in = dv_q_q[k][j];
      end

      assign ge = sh >= {1'b0, den};
      assign nr = ge ? sh - {1'b0, den} : sh;

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_den_q[k+1][j] <= den;
          dv_rem_q[k+1][j] <= nr[DW-1:0];
          dv_q_q[k+1][j]   <= {q_in[QW-2:0], ge};
        end
      end
    end
  end

  // ---------------- s6 sign and square, s7 one minus square
  logic          vld6_q, vld7_q;
  trg_t          t6_q, t7_q;
  logic signed [31:0] sb6_q, sb7_q;
  logic [61:0]   sqa6_q, sqb6_q;
  logic [61:0]   ra7_q, rb7_q;
  logic [QW-1:0] qa, qb;
  dsd_t          c_d;

  assign qa  = dv_q_q[DSTEPS][0];
  assign qb  = dv_q_q[DSTEPS][1];
  assign c_d = dv_c_q[DSTEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en) begin
      vld6_q <= dv_vld_q[DSTEPS];
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t6_q.x    <= c_d.x;
      t6_q.y    <= c_d.y;
      t6_q.lift <= c_d.lift;
      t6_q.cv   <= c_d.cv;
      t6_q.ok   <= c_d.ok;
      t6_q.ca   <= c_d.na ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
      sb6_q     <= c_d.nb ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
      sqa6_q    <= qa * qa;
      sqb6_q    <= qb * qb;
      t7_q      <= t6_q;
      sb7_q     <= sb6_q;
      ra7_q     <= (62'd1 << 60) - sqa6_q;
      rb7_q     <= (62'd1 << 60) - sqb6_q;
    end
  end

  // ---------------- cosine roots
  logic        vld_b;
  logic [30:0] cos_a, cos_b;
  trg_t        t_b;
  logic signed [31:0] sb_b;

  sik_isqrt #(.IW(62), .SW($bits(trg_t))) u_cos_a_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (vld7_q),
    .rad_i    (ra7_q),
    .side_i   (t7_q),
    .vld_o    (vld_b),
    .root_o   (cos_a),
    .rem_nz_o (),
    .side_o   (t_b)
  );

  sik_isqrt #(.IW(62), .SW(32)) u_cos_b_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (vld7_q),
    .rad_i    (rb7_q),
    .side_i   (sb7_q),
    .vld_o    (),
    .root_o   (cos_b),
    .rem_nz_o (),
    .side_o   (sb_b)
  );

  // ---------------- angles
  logic                    vld_c;
  logic signed [ANG_W-1:0] acs_c, asn_c, phi_c;
  logic signed [24:0]      lift_c;
  logic                    cv_c, ok_c;

  sik_cordic #(.STAGES(CORDIC_STAGES), .SW(25)) u_acos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_b),
    .y_i    ($signed({1'b0, cos_a})),
    .x_i    (t_b.ca),
    .side_i (t_b.lift),
    .vld_o  (vld_c),
    .ang_o  (acs_c),
    .side_o (lift_c)
  );

  sik_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_asin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_b),
    .y_i    (sb_b),
    .x_i    ($signed({1'b0, cos_b})),
    .side_i (t_b.cv),
    .vld_o  (),
    .ang_o  (asn_c),
    .side_o (cv_c)
  );

  sik_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_phi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_b),
    .y_i    ({{8{t_b.y[23]}}, t_b.y}),
    .x_i    ({{8{t_b.x[23]}}, t_b.x}),
    .side_i (t_b.ok),
    .vld_o  (),
    .ang_o  (phi_c),
    .side_o (ok_c)
  );

  // ---------------- s9 joint sums, s10 rounding
  logic                    vld9_q, vld10_q;
  logic signed [ANG_W:0]   q2_9_q, q3_9_q;
  logic signed [24:0]      lift9_q, lift10_q;
  logic                    ok9_q, ok10_q;
  logic signed [ANG_W:0]   hp_x, pi_x, acs_x, asn_x, phi_x;
  logic [ANG_W:0]          m2, m3;
  logic [ANG_W:0]          r2m, r3m;
  logic signed [24:0]      q2_10_q, q3_10_q;

  assign hp_x  = (ANG_W+1)'(HALF_PI_Q30);
  assign pi_x  = (ANG_W+1)'(PI_Q30);
  assign acs_x = {acs_c[ANG_W-1], acs_c};
  assign asn_x = {asn_c[ANG_W-1], asn_c};
  assign phi_x = {phi_c[ANG_W-1], phi_c};

  // round half away from zero to rad * 65536
  assign m2  = q2_9_q[ANG_W] ? -q2_9_q : q2_9_q;
  assign m3  = q3_9_q[ANG_W] ? -q3_9_q : q3_9_q;
  assign r2m = (m2 + (ANG_W+1)'(8192)) >> 14;
  assign r3m = (m3 + (ANG_W+1)'(8192)) >> 14;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld9_q  <= 1'b0;
      vld10_q <= 1'b0;
    end else if (en) begin
      vld9_q  <= vld_c;
      vld10_q <= vld9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2_9_q   <= cv_c ? hp_x - phi_x + acs_x : hp_x - acs_x - phi_x;
      q3_9_q   <= cv_c ? pi_x - asn_x : asn_x;
      lift9_q  <= lift_c;
      ok9_q    <= ok_c;
      q2_10_q  <= q2_9_q[ANG_W] ? -$signed({1'b0, r2m[23:0]}) : $signed({1'b0, r2m[23:0]});
      q3_10_q  <= q3_9_q[ANG_W] ? -$signed({1'b0, r3m[23:0]}) : $signed({1'b0, r3m[23:0]});
      lift10_q <= lift9_q;
      ok10_q   <= ok9_q;
    end
  end

  // ---------------- output register: limit checks
  logic               in_rng;
  logic signed [24:0] lift_q;
  logic signed [19:0] sh_q, el_q;
  logic               rng_q;

  assign in_rng = ok10_q &&
                  !lift10_q[24] && (lift10_q[23:0] < lift_lim_q) &&
                  !q2_10_q[24] && (q2_10_q[23:0] < {5'b0, shld_lim_q}) &&
                  !q3_10_q[24] && (q3_10_q[23:0] < {5'b0, elb_lim_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lift_q <= lift10_q;
      rng_q  <= in_rng;
      sh_q   <= in_rng ? q2_10_q[19:0] : '0;
      el_q   <= in_rng ? q3_10_q[19:0] : '0;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.lift_offset    = lift_q;
  assign res_o.shoulder_angle = sh_q;
  assign res_o.elbow_angle    = el_q;
  assign res_o.in_range       = rng_q;

  a_zero_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.in_range |-> res_o.shoulder_angle == '0 && res_o.elbow_angle == '0)
    else $error("joint angles not cleared on out of range word");

  a_within_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.in_range |->
      !res_o.lift_offset[24] && ($unsigned(res_o.shoulder_angle) < {1'b0, shld_lim_q}) &&
      ($unsigned(res_o.elbow_angle) < {1'b0, elb_lim_q}))
    else $error("in range word violates a joint limit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld1_q) && $stable(vld6_q) && $stable(out_vld_q))
    else $error("pipeline moved during a stall");

endmodule

// ===== verif/tb_scara_inverse_kinematics.sv =====
// Testbench of scara_inverse_kinematics: directed and random targets over several register settings.
module tb_scara_inverse_kinematics;
  timeunit 1ns;
  timeprecision 1ps;
  import sik_pkg::*;

  localparam int LATENCY = 105 + CORDIC_STAGES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               convex;
  } target_t;

  typedef struct packed {
    logic signed [24:0] lift;
    logic signed [19:0] shoulder;
    logic signed [19:0] elbow;
    logic               ok;
  } joint_t;

  logic clk_i, rst_ni, cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sik_target_if tgt ();
  sik_joint_if  res ();

  scara_inverse_kinematics i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .tgt_i(tgt), .res_o(res)
  );

  // arm geometry as the block should hold it
  logic [22:0]        arm_l1, arm_l2;
  logic signed [23:0] arm_base;
  logic [23:0]        lim_lift;
  logic [18:0]        lim_shoulder, lim_elbow;

  target_t pending_q[$];
  joint_t  joint_q[$];
  int      err_cnt, cycles, gap_left, stall_left;
  bit      word_taken, idle_on;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint base_ang, z, dx, dy;
    base_ang = 0;
    z = 0;
    if (x < 0) begin
      base_ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    x = x <<< CRD_SHIFT;
    y = y <<< CRD_SHIFT;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= dy; y += dx; z -= longint'(ATAN_Q30[i]);
      end
    end
    return base_ang + z;
  endfunction

  function automatic longint q30_ratio(longint num, longint den);
    longint unsigned m, d, q, rm;
    m = (num < 0) ? -num : num;
    d = den;
    q = m / d;
    rm = m % d;
    for (int k = 0; k < 30; k++) begin
      rm <<= 1;
      q <<= 1;
      if (rm >= d) begin
        rm -= d;
        q |= 1;
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cos_from_sin(longint s);
    return longint'(int_sqrt(longint'(ONE_Q30 * ONE_Q30) - s * s));
  endfunction

  function automatic longint to_q16(longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -(((-v) + 8192) >>> 14);
  endfunction

  function automatic joint_t solve_joints(target_t t);
    joint_t j;
    longint x, y, l1, l2, lift, q2, q3, acd, asd, acn, asn, ca, sb, acs, asg, phi;
    longint unsigned r2, reach, n, rq;
    x = t.x;
    y = t.y;
    l1 = arm_l1;
    l2 = arm_l2;
    lift = longint'(t.z) - longint'(arm_base);
    j = '0;
    j.lift = lift[24:0];
    r2 = x * x + y * y;
    reach = l1 + l2;
    if (r2 != 0 && r2 <= reach * reach) begin
      n = r2 << 16;
      rq = int_sqrt(n);
      if (rq * rq < n) rq++;
      acd = 2 * l1 * longint'(rq);
      asd = 2 * l1 * l2;
      acn = (l1 * l1 + longint'(r2) - l2 * l2) * 256;
      asn = longint'(r2) - l1 * l1 - l2 * l2;
      if (acd > 0 && asd > 0 && (acn < 0 ? -acn : acn) <= acd
          && (asn < 0 ? -asn : asn) <= asd) begin
        ca = q30_ratio(acn, acd);
        sb = q30_ratio(asn, asd);
        acs = angle_of(cos_from_sin(ca), ca);
        asg = angle_of(sb, cos_from_sin(sb));
        phi = angle_of(y, x);
        if (t.convex) begin
          q2 = longint'(HALF_PI_Q30) - phi + acs;
          q3 = longint'(PI_Q30) - asg;
        end else begin
          q2 = longint'(HALF_PI_Q30) - acs - phi;
          q3 = asg;
        end
        q2 = to_q16(q2);
        q3 = to_q16(q3);
        if (lift >= 0 && lift < longint'(lim_lift) && q2 >= 0
            && q2 < longint'(lim_shoulder) && q3 >= 0 && q3 < longint'(lim_elbow)) begin
          j.ok = 1'b1;
          j.shoulder = q2[19:0];
          j.elbow = q3[19:0];
        end
      end
    end
    return j;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // target driver and result ready stalls
  always @(negedge clk_i) begin
    if (tgt.valid && !word_taken) begin
      // hold the word until taken
    end else if (gap_left > 0) begin
      tgt.valid <= 1'b0;
      gap_left--;
    end else if (pending_q.size() != 0) begin
      target_t t;
      t = pending_q.pop_front();
      tgt.valid <= 1'b1;
      tgt.target_x <= t.x;
      tgt.target_y <= t.y;
      tgt.target_z <= t.z;
      tgt.elbow_convex <= t.convex;
      if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
      gap_left = idle_on ? $urandom_range(0, 10) : 0;
    end else begin
      tgt.valid <= 1'b0;
    end
    word_taken = 1'b0;
    if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor: predict on accept, check results in order
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni && tgt.valid && tgt.ready) begin
      target_t t;
      t.x = tgt.target_x;
      t.y = tgt.target_y;
      t.z = tgt.target_z;
      t.convex = tgt.elbow_convex;
      joint_q.push_back(solve_joints(t));
      word_taken = 1'b1;
    end
    if (rst_ni && res.valid && res.ready) begin
      joint_t want;
      if (joint_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = joint_q.pop_front();
        if (res.lift_offset !== want.lift || res.shoulder_angle !== want.shoulder
            || res.elbow_angle !== want.elbow || res.in_range !== want.ok) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp lift %0d sh %0d el %0d ok %0b, got %0d %0d %0d %0b",
                     want.lift, want.shoulder, want.elbow, want.ok, res.lift_offset,
                     res.shoulder_angle, res.elbow_angle, res.in_range);
        end
      end
      stall_left = idle_on ? $urandom_range(0, 10) : 0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_L1:    arm_l1 = val[22:0];
      CFG_L2:    arm_l2 = val[22:0];
      CFG_BASE:  arm_base = val;
      CFG_LIFT:  lim_lift = val;
      CFG_SHLD:  lim_shoulder = val[18:0];
      CFG_ELBOW: lim_elbow = val[18:0];
      default: ;
    endcase
  endtask

  task automatic set_arm(input logic [22:0] l1, input logic [22:0] l2,
                         input logic [23:0] hb, input logic [23:0] ll,
                         input logic [18:0] sl, input logic [18:0] el);
    write_reg(CFG_L1, {1'b0, l1});
    write_reg(CFG_L2, {1'b0, l2});
    write_reg(CFG_BASE, hb);
    write_reg(CFG_LIFT, ll);
    write_reg(CFG_SHLD, {5'b0, sl});
    write_reg(CFG_ELBOW, {5'b0, el});
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || tgt.valid || joint_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic add(input int x, input int y, input int z, input bit cv);
    target_t t;
    t.x = 24'(x);
    t.y = 24'(y);
    t.z = 24'(z);
    t.convex = cv;
    pending_q.push_back(t);
  endtask

  function automatic int coord_in(longint lim);
    if (lim > 8388607) lim = 8388607;
    return int'(longint'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // mostly points within +-reach, half of them at plausible heights, the rest full-range noise
  task automatic random_targets(input int count);
    longint reach;
    int z;
    reach = longint'(arm_l1) + longint'(arm_l2);
    for (int i = 0; i < count; i++) begin
      if (reach > 0 && $urandom_range(0, 4) != 0) begin
        z = ($urandom_range(0, 1) != 0)
            ? int'(longint'(arm_base) + $urandom_range(0, 200000)) : $urandom;
        add(coord_in(reach), coord_in(reach), z, 1'($urandom_range(0, 1)));
      end else begin
        add($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    tgt.valid = 1'b0;
    tgt.target_x = '0;
    tgt.target_y = '0;
    tgt.target_z = '0;
    tgt.elbow_convex = 1'b0;
    res.ready = 1'b0;
    {arm_l1, arm_l2, arm_base, lim_lift, lim_shoulder, lim_elbow} = '0;
    err_cnt = 0;
    cycles = 0;
    gap_left = 0;
    stall_left = 0;
    idle_on = 1'b1;
    word_taken = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: zero links, everything out of range
    add(1000, 2000, 0, 0);
    add(-8388608, 8388607, -8388608, 1);
    random_targets(20);
    drain();

    set_arm(23'd25600, 23'd25600, 24'd0, 24'hFFFFFF, 19'd411775, 19'd411775);
    add(0, 30000, 100, 0);           // x zero
    add(0, 30000, 100, 1);
    add(-20000, 0, 0, 0);            // negative x, y zero
    add(-20000, -15000, 0, 1);       // negative x, negative y
    add(20000, -15000, 0, 0);
    add(0, 0, 0, 0);                 // zero reach
    add(51200, 0, 0, 0);             // full stretch
    add(51200, 0, 0, 1);
    add(51201, 0, 0, 0);             // just beyond reach
    add(1, 0, 0, 0);
    add(8388607, 8388607, 8388607, 1);
    add(-8388608, -8388608, -8388608, 0);
    add(30000, 30000, -1, 1);        // negative lift
    random_targets(200);
    drain();

    write_reg(CFG_UNUSED, 24'hFFFFFF);
    set_arm(23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 19'd411775, 19'd411775);
    add(8388607, 0, 8388607, 0);
    add(-8388608, 8388607, 8388607, 1);
    random_targets(150);
    drain();

    set_arm(23'd30000, 23'd20000, -24'sd5000, 24'd100000, 19'd205887, 19'd205887);
    random_targets(200);
    drain();

    set_arm(23'd0, 23'd10000, 24'h800000, 24'd0, 19'd0, 19'd0);
    add(5000, 0, 0, 0);
    random_targets(40);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_arm(23'($urandom_range(1, 60000)), 23'($urandom_range(1, 60000)), 24'($urandom),
              24'($urandom_range(0, 16777215)), 19'($urandom_range(0, 411775)),
              19'($urandom_range(0, 411775)));
      random_targets(80);
      drain();
    end

    if (err_cnt == 0 && joint_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/sik_pkg.sv
rtl/sik_target_if.sv
rtl/sik_joint_if.sv
rtl/sik_isqrt.sv
rtl/sik_cordic.sv
rtl/scara_inverse_kinematics.sv
verif/tb_scara_inverse_kinematics.sv
